// ===== rtl/assert_macros.svh =====
// Assertion helpers for the checker modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define MI_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define MI_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

// ===== rtl/mi3_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mi3_pkg;

   // Element format: signed Q16.16
   localparam int ELEM_W = 32;
   localparam int FRAC_W = 16;

   // Exact intermediate widths
   localparam int PW = 2 * ELEM_W;          // element product
   localparam int AW = 2 * ELEM_W + 1;      // cofactor
   localparam int DW = 3 * ELEM_W + 2;      // determinant
   localparam int NW = 2 * ELEM_W + 2 * FRAC_W;   // scaled cofactor magnitude
   localparam int CW = (NW > DW + ELEM_W) ? NW : DW + ELEM_W;   // divider compare

   // Cycles from request to result
   localparam int LATENCY = ELEM_W + 10;

   typedef struct packed {
      logic signed [ELEM_W-1:0] in_r0c0;
      logic signed [ELEM_W-1:0] in_r0c1;
      logic signed [ELEM_W-1:0] in_r0c2;
      logic signed [ELEM_W-1:0] in_r1c0;
      logic signed [ELEM_W-1:0] in_r1c1;
      logic signed [ELEM_W-1:0] in_r1c2;
      logic signed [ELEM_W-1:0] in_r2c0;
      logic signed [ELEM_W-1:0] in_r2c1;
      logic signed [ELEM_W-1:0] in_r2c2;
   } req_type;

   typedef struct packed {
      logic signed [ELEM_W-1:0] inv_r0c0;
      logic signed [ELEM_W-1:0] inv_r0c1;
      logic signed [ELEM_W-1:0] inv_r0c2;
      logic signed [ELEM_W-1:0] inv_r1c0;
      logic signed [ELEM_W-1:0] inv_r1c1;
      logic signed [ELEM_W-1:0] inv_r1c2;
      logic signed [ELEM_W-1:0] inv_r2c0;
      logic signed [ELEM_W-1:0] inv_r2c1;
      logic signed [ELEM_W-1:0] inv_r2c2;
      logic signed [ELEM_W-1:0] det_value;
      logic                     singular;
   } rsp_type;

endpackage

`default_nettype wire

// ===== rtl/mi3_div_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none

// One inverse element: scaled cofactor magnitude over determinant magnitude,
// one quotient bit per stage, then sign and saturation.
module mi3_div_lane
   import mi3_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic [NW-1:0]            num,
   input  wire logic [DW-1:0]            dmag,
   input  wire logic                     neg,
   output logic signed [ELEM_W-1:0]      result
);

   localparam logic [ELEM_W-1:0] HALF = {1'b1, {(ELEM_W-1){1'b0}}};
   localparam logic [ELEM_W-1:0] MAXP = {1'b0, {(ELEM_W-1){1'b1}}};

   logic [NW-1:0]     rem_ff [0:ELEM_W];
   logic [ELEM_W-1:0] quo_ff [0:ELEM_W];
   logic [DW-1:0]     den_ff [0:ELEM_W];
   logic              neg_ff [0:ELEM_W];
   logic              ovf_ff [0:ELEM_W];
   logic              ovf_in;
   logic [ELEM_W-1:0] res_in;
   logic [ELEM_W-1:0] res_ff;

   // Flag quotients that do not fit the element width
   always_comb begin
      ovf_in = CW'(num) >= (CW'(dmag) << ELEM_W);
   end

   // Load the divider
   always_ff @(posedge clock) begin
      rem_ff[0] <= num;
      quo_ff[0] <= '0;
      den_ff[0] <= dmag;
      neg_ff[0] <= neg;
      ovf_ff[0] <= ovf_in;
   end

   // Restoring division, most significant quotient bit first
   for (genvar s = 0; s < ELEM_W; s++) begin : g_step
      localparam int K = ELEM_W - 1 - s;
      logic [CW-1:0] dsh_in;
      logic [CW-1:0] rx_in;
      logic          take_in;

      always_comb begin
         dsh_in  = CW'(den_ff[s]) << K;
         rx_in   = CW'(rem_ff[s]);
         take_in = rx_in >= dsh_in;
      end

      always_ff @(posedge clock) begin
         rem_ff[s+1] <= take_in ? NW'(rx_in - dsh_in) : rem_ff[s];
         quo_ff[s+1] <= quo_ff[s] | (take_in ? (ELEM_W'(1) << K) : '0);
         den_ff[s+1] <= den_ff[s];
         neg_ff[s+1] <= neg_ff[s];
         ovf_ff[s+1] <= ovf_ff[s];
      end
   end

   // Apply sign and saturate
   always_comb begin
      if (neg_ff[ELEM_W]) begin
         if (ovf_ff[ELEM_W] || (quo_ff[ELEM_W] > HALF)) begin
            res_in = HALF;
         end else begin
            res_in = ELEM_W'(0) - quo_ff[ELEM_W];
         end
      end else begin
         if (ovf_ff[ELEM_W] || quo_ff[ELEM_W][ELEM_W-1]) begin
            res_in = MAXP;
         end else begin
            res_in = quo_ff[ELEM_W];
         end
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   assign result = $signed(res_ff);

endmodule

`default_nettype wire

// ===== rtl/matrix_inverse_3x3.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel    Ports                 Handshake
// request    req_data (req_type)   start high, busy low at a rising edge
// result     rsp_data (rsp_type)   rsp_valid high for one cycle
//
// Accepts one matrix every cycle; busy stays low.
// Each result passes through the 32-stage restoring divider in each of the
// nine inverse lanes.
// Synchronous reset clears the valid pipeline; data in flight is dropped.
// The receiver cannot stall, so the pipeline advances every cycle.
module matrix_inverse_3x3
   import mi3_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_data,
   output logic         rsp_valid,
   output rsp_type      rsp_data
);

   localparam logic signed [DW-1:0] DMAX = DW'({1'b0, {(ELEM_W-1){1'b1}}});
   localparam logic signed [DW-1:0] DMIN = -DW'({1'b1, {(ELEM_W-1){1'b0}}});
   localparam int DLY = ELEM_W + 2;

   logic [LATENCY-1:0] valid_ff;
   req_type            in_ff;

   logic signed [ELEM_W-1:0] el_in [0:8];
   logic signed [PW-1:0]     pa_ff [0:8];
   logic signed [PW-1:0]     pb_ff [0:8];
   logic signed [ELEM_W-1:0] r0_ff2 [0:2];
   logic signed [ELEM_W-1:0] r0_ff3 [0:2];
   logic signed [AW-1:0]     adj_ff3 [0:8];
   logic signed [AW-1:0]     adj_ff4 [0:8];
   logic signed [AW-1:0]     adj_ff5 [0:8];
   logic signed [AW-1:0]     adj_ff6 [0:8];
   logic signed [AW:0]       ph_ff [0:2];
   logic signed [AW:0]       pl_ff [0:2];
   logic signed [DW-1:0]     t_ff [0:2];
   logic signed [DW-1:0]     det_ff;

   logic signed [DW-1:0]     dneg_in;
   logic signed [DW-1:0]     dsh_in;
   logic [DW-1:0]            dmag_ff;
   logic [NW-1:0]            num_ff [0:8];
   logic                     nneg_ff [0:8];
   logic                     sing_ff [0:DLY];
   logic signed [ELEM_W-1:0] detv_in;
   logic signed [ELEM_W-1:0] detv_ff [0:DLY];
   logic signed [ELEM_W-1:0] lane_res [0:8];
   rsp_type                  rsp_in;
   rsp_type                  rsp_ff;

   assign busy = 1'b0;

   // Advance the valid bits with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[LATENCY-2:0], start & ~busy};
      end
   end

   // Capture the request
   always_ff @(posedge clock) begin
      in_ff <= req_data;
   end

   always_comb begin
      el_in[0] = in_ff.in_r0c0;
      el_in[1] = in_ff.in_r0c1;
      el_in[2] = in_ff.in_r0c2;
      el_in[3] = in_ff.in_r1c0;
      el_in[4] = in_ff.in_r1c1;
      el_in[5] = in_ff.in_r1c2;
      el_in[6] = in_ff.in_r2c0;
      el_in[7] = in_ff.in_r2c1;
      el_in[8] = in_ff.in_r2c2;
   end

   // Form the cofactor products, then the cofactors
   for (genvar i = 0; i < 3; i++) begin : g_row
      for (genvar j = 0; j < 3; j++) begin : g_col
         localparam int R1 = (j + 1) % 3;
         localparam int R2 = (j + 2) % 3;
         localparam int C1 = (i + 1) % 3;
         localparam int C2 = (i + 2) % 3;
         always_ff @(posedge clock) begin
            pa_ff[i*3+j]   <= el_in[R1*3+C1] * el_in[R2*3+C2];
            pb_ff[i*3+j]   <= el_in[R1*3+C2] * el_in[R2*3+C1];
            adj_ff3[i*3+j] <= AW'(pa_ff[i*3+j]) - AW'(pb_ff[i*3+j]);
         end
      end
   end

   // Determinant partial products, split cofactor into high and low halves
   for (genvar j = 0; j < 3; j++) begin : g_det
      always_ff @(posedge clock) begin
         r0_ff2[j] <= el_in[j];
         r0_ff3[j] <= r0_ff2[j];
         ph_ff[j]  <= r0_ff3[j] * $signed(adj_ff3[j*3][AW-1:ELEM_W]);
         pl_ff[j]  <= r0_ff3[j] * $signed({1'b0, adj_ff3[j*3][ELEM_W-1:0]});
         t_ff[j]   <= (DW'(ph_ff[j]) <<< ELEM_W) + DW'(pl_ff[j]);
      end
   end

   // Carry cofactors and sum the determinant
   always_ff @(posedge clock) begin
      adj_ff4 <= adj_ff3;
      adj_ff5 <= adj_ff4;
      adj_ff6 <= adj_ff5;
      det_ff  <= t_ff[0] + t_ff[1] + t_ff[2];
   end

   // Floor and saturate the determinant, take magnitudes
   always_comb begin
      dneg_in = -det_ff;
      dsh_in  = det_ff >>> (2 * FRAC_W);
      if (dsh_in > DMAX) begin
         detv_in = DMAX[ELEM_W-1:0];
      end else if (dsh_in < DMIN) begin
         detv_in = DMIN[ELEM_W-1:0];
      end else begin
         detv_in = dsh_in[ELEM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      dmag_ff    <= det_ff[DW-1] ? dneg_in : det_ff;
      sing_ff[0] <= (det_ff == '0);
      detv_ff[0] <= detv_in;
   end

   for (genvar k = 0; k < 9; k++) begin : g_lane
      logic signed [AW-1:0] aneg_in;
      assign aneg_in = -adj_ff6[k];
      always_ff @(posedge clock) begin
         num_ff[k]  <= {(adj_ff6[k][AW-1] ? aneg_in[PW-1:0] : adj_ff6[k][PW-1:0]),
                        {(2*FRAC_W){1'b0}}};
         nneg_ff[k] <= adj_ff6[k][AW-1] ^ det_ff[DW-1];
      end

      mi3_div_lane u_lane (
         .clock  (clock),
         .num    (num_ff[k]),
         .dmag   (dmag_ff),
         .neg    (nneg_ff[k]),
         .result (lane_res[k])
      );
   end

   // Hold singular flag and determinant alongside the divider
   for (genvar d = 0; d < DLY; d++) begin : g_dly
      always_ff @(posedge clock) begin
         sing_ff[d+1] <= sing_ff[d];
         detv_ff[d+1] <= detv_ff[d];
      end
   end

   // Assemble the result, zero everything for a singular matrix
   always_comb begin
      rsp_in.inv_r0c0  = lane_res[0];
      rsp_in.inv_r0c1  = lane_res[1];
      rsp_in.inv_r0c2  = lane_res[2];
      rsp_in.inv_r1c0  = lane_res[3];
      rsp_in.inv_r1c1  = lane_res[4];
      rsp_in.inv_r1c2  = lane_res[5];
      rsp_in.inv_r2c0  = lane_res[6];
      rsp_in.inv_r2c1  = lane_res[7];
      rsp_in.inv_r2c2  = lane_res[8];
      rsp_in.det_value = detv_ff[DLY];
      rsp_in.singular  = 1'b0;
      if (sing_ff[DLY]) begin
         rsp_in          = '0;
         rsp_in.singular = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = valid_ff[LATENCY-1];
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

// ===== rtl/mi3_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// Port-level checks on the inverse pipeline.
module mi3_checker
   import mi3_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    start,
   input wire logic    busy,
   input wire logic    rsp_valid,
   input wire rsp_type rsp_data
);

   // Never refuse a request
   `MI_ASSERT(a_busy_low, !busy, "busy raised")

   // Drop all results after reset
   `MI_ASSERT_ALWAYS(a_reset_clears, reset |=> !rsp_valid, "result after reset")

   // Every result traces back to a request at fixed latency
   `MI_ASSERT(a_latency, rsp_valid |-> $past(start && !busy, LATENCY), "orphan result")

   // Singular results carry a zero determinant and zero diagonal inverse elements
   `MI_ASSERT(a_singular_zero, (rsp_valid && rsp_data.singular) |-> (rsp_data.det_value == 0 && rsp_data.inv_r0c0 == 0 && rsp_data.inv_r1c1 == 0 && rsp_data.inv_r2c2 == 0), "singular result not zero")

endmodule

bind matrix_inverse_3x3 mi3_checker u_mi3_checker (.*);

`default_nettype wire
